>>> sv/tdclk_pkg.sv
`default_nettype none

package tdclk_pkg;

   typedef logic [3:0] op_type;

   localparam op_type OP_NONE       = 4'd0;
   localparam op_type OP_TICK       = 4'd1;
   localparam op_type OP_LAP_TOGGLE = 4'd2;
   localparam op_type OP_LAP_CLEAR  = 4'd3;
   localparam op_type OP_RING_ACK   = 4'd4;
   localparam op_type OP_OPEN_TIME  = 4'd5;
   localparam op_type OP_OPEN_ALARM = 4'd6;
   localparam op_type OP_CLOSE      = 4'd7;
   localparam op_type OP_SEC_UP     = 4'd8;
   localparam op_type OP_MIN_UP     = 4'd9;
   localparam op_type OP_HOUR_UP    = 4'd10;
   localparam op_type OP_SEC_DOWN   = 4'd11;
   localparam op_type OP_MIN_DOWN   = 4'd12;
   localparam op_type OP_HOUR_DOWN  = 4'd13;

   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_BYTE       = 3'd1;
   localparam logic [2:0] CMD_LAP_TOGGLE = 3'd2;
   localparam logic [2:0] CMD_LAP_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_RING_ACK   = 3'd4;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_B = 8'h42;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_D = 8'h44;
   localparam logic [7:0] CHAR_E = 8'h45;
   localparam logic [7:0] CHAR_F = 8'h46;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_H = 8'h48;
   localparam logic [7:0] CHAR_I = 8'h49;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_TIME  = 2'd1;
   localparam logic [1:0] MODE_ALARM = 2'd2;

   localparam logic [6:0] TOP_SEC_MIN = 7'd59;
   localparam logic [6:0] TOP_HOUR    = 7'd23;
   localparam logic [6:0] TOP_LAP_HR  = 7'd99;

   localparam int RSP_WIDTH = 64;

   typedef struct packed {
      logic   valid;
      op_type op;
   } push_type;

   function automatic logic [6:0] wrap_up(input logic [6:0] v, input logic [6:0] top);
      return (v >= top) ? 7'd0 : v + 7'd1;
   endfunction

   function automatic logic [6:0] wrap_down(input logic [6:0] v, input logic [6:0] top);
      return (v == 7'd0 || v > top) ? top : v - 7'd1;
   endfunction

endpackage

`default_nettype wire

>>> sv/tdclk_front.sv
`default_nettype none

module tdclk_front (
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic [7:0]        req_tuser,
   input  wire logic              queue_full,
   output tdclk_pkg::push_type    push
);

   tdclk_pkg::op_type byte_op;

   always_comb begin
      case (req_tdata)
         tdclk_pkg::CHAR_A: byte_op = tdclk_pkg::OP_OPEN_TIME;
         tdclk_pkg::CHAR_B: byte_op = tdclk_pkg::OP_OPEN_ALARM;
         tdclk_pkg::CHAR_C: byte_op = tdclk_pkg::OP_SEC_UP;
         tdclk_pkg::CHAR_D: byte_op = tdclk_pkg::OP_MIN_UP;
         tdclk_pkg::CHAR_E: byte_op = tdclk_pkg::OP_HOUR_UP;
         tdclk_pkg::CHAR_F: byte_op = tdclk_pkg::OP_SEC_DOWN;
         tdclk_pkg::CHAR_G: byte_op = tdclk_pkg::OP_MIN_DOWN;
         tdclk_pkg::CHAR_H: byte_op = tdclk_pkg::OP_HOUR_DOWN;
         tdclk_pkg::CHAR_I: byte_op = tdclk_pkg::OP_CLOSE;
         default:           byte_op = tdclk_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      push.valid = req_tvalid && !queue_full;
      case (req_tuser[2:0])
         tdclk_pkg::CMD_TICK:       push.op = tdclk_pkg::OP_TICK;
         tdclk_pkg::CMD_BYTE:       push.op = byte_op;
         tdclk_pkg::CMD_LAP_TOGGLE: push.op = tdclk_pkg::OP_LAP_TOGGLE;
         tdclk_pkg::CMD_LAP_CLEAR:  push.op = tdclk_pkg::OP_LAP_CLEAR;
         tdclk_pkg::CMD_RING_ACK:   push.op = tdclk_pkg::OP_RING_ACK;
         default:                   push.op = tdclk_pkg::OP_NONE;
      endcase
   end

   assign req_tready = !queue_full;

endmodule

`default_nettype wire

>>> sv/tdclk_queue.sv
`default_nettype none

module tdclk_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tdclk_pkg::push_type push,
   output logic                    full,
   output logic                    head_valid,
   output tdclk_pkg::op_type       head_op,
   input  wire logic               pop
);

   tdclk_pkg::op_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_op    = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule

`default_nettype wire

>>> sv/tdclk_back.sv
`default_nettype none

module tdclk_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [7:0]                        csr_wdata,
   input  wire logic                              head_valid,
   input  wire tdclk_pkg::op_type                 head_op,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [tdclk_pkg::RSP_WIDTH-1:0]        rsp_tdata
);

   logic [3:0] tone_ff;
   logic [4:0] hour_ff, hour_in;
   logic [5:0] min_ff, min_in;
   logic [5:0] sec_ff, sec_in;
   logic [6:0] lap_hour_ff, lap_hour_in;
   logic [5:0] lap_min_ff, lap_min_in;
   logic [5:0] lap_sec_ff, lap_sec_in;
   logic [4:0] wake_hour_ff, wake_hour_in;
   logic [5:0] wake_min_ff, wake_min_in;
   logic [5:0] wake_sec_ff, wake_sec_in;
   logic       lap_run_ff, lap_run_in;
   logic       ring_ff, ring_in;
   logic [1:0] mode_ff, mode_in;
   logic       rsp_valid_ff;
   logic [tdclk_pkg::RSP_WIDTH-1:0] rsp_data_ff;
   logic       adj_time, adj_alarm;

   assign pop        = head_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign adj_time   = (mode_ff == tdclk_pkg::MODE_TIME);
   assign adj_alarm  = (mode_ff == tdclk_pkg::MODE_ALARM);

   always_comb begin
      hour_in      = hour_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      lap_hour_in  = lap_hour_ff;
      lap_min_in   = lap_min_ff;
      lap_sec_in   = lap_sec_ff;
      wake_hour_in = wake_hour_ff;
      wake_min_in  = wake_min_ff;
      wake_sec_in  = wake_sec_ff;
      lap_run_in   = lap_run_ff;
      ring_in      = ring_ff;
      mode_in      = mode_ff;
      case (head_op)
         tdclk_pkg::OP_TICK: begin
            sec_in = 6'(tdclk_pkg::wrap_up(7'(sec_ff), tdclk_pkg::TOP_SEC_MIN));
            if (sec_in == 6'd0) begin
               min_in = 6'(tdclk_pkg::wrap_up(7'(min_ff), tdclk_pkg::TOP_SEC_MIN));
               if (min_in == 6'd0) begin
                  hour_in = 5'(tdclk_pkg::wrap_up(7'(hour_ff), tdclk_pkg::TOP_HOUR));
               end
            end
            if (lap_run_ff) begin
               lap_sec_in = 6'(tdclk_pkg::wrap_up(7'(lap_sec_ff), tdclk_pkg::TOP_SEC_MIN));
               if (lap_sec_in == 6'd0) begin
                  lap_min_in = 6'(tdclk_pkg::wrap_up(7'(lap_min_ff), tdclk_pkg::TOP_SEC_MIN));
                  if (lap_min_in == 6'd0) begin
                     lap_hour_in = tdclk_pkg::wrap_up(lap_hour_ff, tdclk_pkg::TOP_LAP_HR);
                  end
               end
            end
            if (tone_ff != 4'd0 && hour_in == wake_hour_ff && min_in == wake_min_ff &&
                sec_in == wake_sec_ff) begin
               ring_in = 1'b1;
            end
         end
         tdclk_pkg::OP_LAP_TOGGLE: lap_run_in = !lap_run_ff;
         tdclk_pkg::OP_LAP_CLEAR: begin
            lap_run_in  = 1'b0;
            lap_hour_in = 7'd0;
            lap_min_in  = 6'd0;
            lap_sec_in  = 6'd0;
         end
         tdclk_pkg::OP_RING_ACK: ring_in = 1'b0;
         tdclk_pkg::OP_OPEN_TIME: begin
            if (mode_ff == tdclk_pkg::MODE_IDLE) begin
               mode_in = tdclk_pkg::MODE_TIME;
            end
         end
         tdclk_pkg::OP_OPEN_ALARM: begin
            if (mode_ff == tdclk_pkg::MODE_IDLE) begin
               mode_in = tdclk_pkg::MODE_ALARM;
            end
         end
         tdclk_pkg::OP_CLOSE: begin
            if (mode_ff != tdclk_pkg::MODE_IDLE) begin
               mode_in = tdclk_pkg::MODE_IDLE;
            end
         end
         tdclk_pkg::OP_SEC_UP: begin
            if (adj_time) begin
               sec_in = 6'(tdclk_pkg::wrap_up(7'(sec_ff), tdclk_pkg::TOP_SEC_MIN));
            end else if (adj_alarm) begin
               wake_sec_in = 6'(tdclk_pkg::wrap_up(7'(wake_sec_ff), tdclk_pkg::TOP_SEC_MIN));
            end
         end
         tdclk_pkg::OP_MIN_UP: begin
            if (adj_time) begin
               min_in = 6'(tdclk_pkg::wrap_up(7'(min_ff), tdclk_pkg::TOP_SEC_MIN));
            end else if (adj_alarm) begin
               wake_min_in = 6'(tdclk_pkg::wrap_up(7'(wake_min_ff), tdclk_pkg::TOP_SEC_MIN));
            end
         end
         tdclk_pkg::OP_HOUR_UP: begin
            if (adj_time) begin
               hour_in = 5'(tdclk_pkg::wrap_up(7'(hour_ff), tdclk_pkg::TOP_HOUR));
            end else if (adj_alarm) begin
               wake_hour_in = 5'(tdclk_pkg::wrap_up(7'(wake_hour_ff), tdclk_pkg::TOP_HOUR));
            end
         end
         tdclk_pkg::OP_SEC_DOWN: begin
            if (adj_time) begin
               sec_in = 6'(tdclk_pkg::wrap_down(7'(sec_ff), tdclk_pkg::TOP_SEC_MIN));
            end else if (adj_alarm) begin
               wake_sec_in = 6'(tdclk_pkg::wrap_down(7'(wake_sec_ff), tdclk_pkg::TOP_SEC_MIN));
            end
         end
         tdclk_pkg::OP_MIN_DOWN: begin
            if (adj_time) begin
               min_in = 6'(tdclk_pkg::wrap_down(7'(min_ff), tdclk_pkg::TOP_SEC_MIN));
            end else if (adj_alarm) begin
               wake_min_in = 6'(tdclk_pkg::wrap_down(7'(wake_min_ff), tdclk_pkg::TOP_SEC_MIN));
            end
         end
         tdclk_pkg::OP_HOUR_DOWN: begin
            if (adj_time) begin
               hour_in = 5'(tdclk_pkg::wrap_down(7'(hour_ff), tdclk_pkg::TOP_HOUR));
            end else if (adj_alarm) begin
               wake_hour_in = 5'(tdclk_pkg::wrap_down(7'(wake_hour_ff), tdclk_pkg::TOP_HOUR));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff <= 4'd0;
      end else if (csr_we) begin
         tone_ff <= csr_wdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff      <= 5'd0;
         min_ff       <= 6'd0;
         sec_ff       <= 6'd0;
         lap_hour_ff  <= 7'd0;
         lap_min_ff   <= 6'd0;
         lap_sec_ff   <= 6'd0;
         wake_hour_ff <= 5'd0;
         wake_min_ff  <= 6'd0;
         wake_sec_ff  <= 6'd0;
         lap_run_ff   <= 1'b0;
         ring_ff      <= 1'b0;
         mode_ff      <= tdclk_pkg::MODE_IDLE;
      end else if (pop) begin
         hour_ff      <= hour_in;
         min_ff       <= min_in;
         sec_ff       <= sec_in;
         lap_hour_ff  <= lap_hour_in;
         lap_min_ff   <= lap_min_in;
         lap_sec_ff   <= lap_sec_in;
         wake_hour_ff <= wake_hour_in;
         wake_min_ff  <= wake_min_in;
         wake_sec_ff  <= wake_sec_in;
         lap_run_ff   <= lap_run_in;
         ring_ff      <= ring_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= {7'd0, mode_in, lap_run_in, ring_in,
                         wake_sec_in, wake_min_in, wake_hour_in,
                         lap_sec_in, lap_min_in, lap_hour_in,
                         sec_in, min_in, hour_in};
      end
   end

endmodule

`default_nettype wire

>>> sv/time_of_day_clock_alarm_stopwatch.sv
`default_nettype none

// A 24-hour clock with an alarm setting and a 99-hour stopwatch, driven by one
// transaction per event: a one-second tick, an adjustment command character, or a
// stopwatch or alarm control. Every request transaction yields exactly one response
// transaction holding the whole state after that event. One transaction is taken
// per cycle while the command queue is not full; a response passes through the
// two-entry command queue and then the registered response stage. csr_wdata
// sets the alarm tone; zero disables the alarm, and it must be written only when
// the block is idle; the block itself does not enforce this.
module time_of_day_clock_alarm_stopwatch (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata,    // alarm_tone[3:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // cmd_byte[7:0]
   input  wire logic [7:0]  req_tuser,    // cmd[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // clock_hours, clock_minutes, clock_seconds, lap_hours, lap_minutes,
   // lap_seconds, wake_hours, wake_minutes, wake_seconds, ringing,
   // lap_running, adjust_mode, from bit 0 up
   output logic [63:0]      rsp_tdata
);

   tdclk_pkg::push_type push;
   tdclk_pkg::op_type   head_op;
   logic                queue_full;
   logic                head_valid;
   logic                pop;

   tdclk_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push)
   );

   tdclk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop)
   );

   tdclk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
